>>> design/spq_pkg.sv
// Package: shared constants for the stable priority pipe queue.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int unsigned DefDepth       = 16;
  localparam int unsigned DefPrioBits    = 8;
  localparam int unsigned DefPayloadBits = 32;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned StatusW = 3;

  localparam logic [CmdW-1:0] CMD_INSERT       = 2'd0;
  localparam logic [CmdW-1:0] CMD_REMOVE       = 2'd1;
  localparam logic [CmdW-1:0] CMD_CLOSE_WRITER = 2'd2;
  localparam logic [CmdW-1:0] CMD_CLOSE_READER = 2'd3;

  localparam logic [StatusW-1:0] ST_OK           = 3'd0;
  localparam logic [StatusW-1:0] ST_REFUSED      = 3'd1;
  localparam logic [StatusW-1:0] ST_FULL         = 3'd2;
  localparam logic [StatusW-1:0] ST_EMPTY_WAIT   = 3'd3;
  localparam logic [StatusW-1:0] ST_EMPTY_CLOSED = 3'd4;

endpackage

>>> design/spq_mem.sv
// Task store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module spq_mem import spq_pkg::*; #(
  parameter int unsigned DEPTH        = DefDepth,
  parameter int unsigned PRIO_BITS    = DefPrioBits,
  parameter int unsigned PAYLOAD_BITS = DefPayloadBits,
  localparam int unsigned AW          = $clog2(DEPTH)
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AW-1:0]           waddr_i,
  input  logic [PRIO_BITS-1:0]    wprio_i,
  input  logic [PAYLOAD_BITS-1:0] wpay_i,
  input  logic [AW-1:0]           raddr_i,
  output logic [PRIO_BITS-1:0]    rprio_o,
  output logic [PAYLOAD_BITS-1:0] rpay_o
);

  logic [PRIO_BITS-1:0]    prio_mem [DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_mem  [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      prio_mem[waddr_i] <= wprio_i;
      pay_mem[waddr_i]  <= wpay_i;
    end
    rprio_o <= prio_mem[raddr_i];
    rpay_o  <= pay_mem[raddr_i];
  end

endmodule

>>> design/stable_priority_pipe_queue.sv
// Top level: stable priority pipe queue with a memory-held sorted ring.
`timescale 1ns / 1ps
// Usage:
//  - Input channel (in_valid_i/in_ready_o) carries one command per request:
//    insert, remove head, close writer end, close reader end.
//  - Output channel (out_valid_o/out_ready_i) returns exactly one result per
//    request: status, removed task (zero when none) and occupancy after it.
//  - Tasks sit in a circular store in one synchronous RAM, ordered with the
//    highest priority at the head; equal priorities keep arrival order.
//  - Close commands and refused/full/empty cases answer straight from idle.
//  - Remove does one RAM read of the head, then forms the result in S_REM.
//  - Insert walks from the tail toward the head, moving one entry per
//    S_INS_RD/S_INS_CHK pass (read, then compare and write back) past each
//    queued task of lower priority; it stops at a task of equal or higher
//    priority, or at the head. The single RAM port pair sets this pace.
//  - A new request is taken once the previous result has left or is leaving
//    the output register; a stalled receiver holds the result and the block.
//  - Reset: empty queue, both ends open, pipe active. The RAM is not cleared;
//    only entries inside the occupied ring are ever read.
module stable_priority_pipe_queue import spq_pkg::*; #(
  parameter int unsigned DEPTH        = DefDepth,
  parameter int unsigned PRIO_BITS    = DefPrioBits,
  parameter int unsigned PAYLOAD_BITS = DefPayloadBits,
  localparam int unsigned AW          = $clog2(DEPTH),
  localparam int unsigned CW          = $clog2(DEPTH + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [CmdW-1:0]         cmd_i,
  input  logic [PRIO_BITS-1:0]    task_priority_i,
  input  logic [PAYLOAD_BITS-1:0] task_payload_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [StatusW-1:0]      status_o,
  output logic [PRIO_BITS-1:0]    out_priority_o,
  output logic [PAYLOAD_BITS-1:0] out_payload_o,
  output logic [CW-1:0]           occupancy_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_RD  = 3'd1;
  localparam logic [2:0] S_INS_CHK = 3'd2;
  localparam logic [2:0] S_REM     = 3'd3;

  localparam logic [CW-1:0] Full  = CW'(DEPTH);
  localparam logic [AW:0]   DepW  = (AW+1)'(DEPTH);

  logic [2:0]              state_q, state_d;
  logic [CW-1:0]           count_q, count_d;
  logic [AW-1:0]           head_q, head_d;
  logic [CW-1:0]           idx_q, idx_d;       // logical slot being filled
  logic                    wr_open_q, wr_open_d;
  logic                    rd_open_q, rd_open_d;
  logic                    active_q, active_d;
  logic [PRIO_BITS-1:0]    new_prio_q, new_prio_d;
  logic [PAYLOAD_BITS-1:0] new_pay_q, new_pay_d;

  logic                    ovalid_q, ovalid_d;
  logic [StatusW-1:0]      ostat_q, ostat_d;
  logic [PRIO_BITS-1:0]    oprio_q, oprio_d;
  logic [PAYLOAD_BITS-1:0] opay_q, opay_d;
  logic [CW-1:0]           oocc_q, oocc_d;

  logic                    we;
  logic [AW-1:0]           waddr, raddr;
  logic [PRIO_BITS-1:0]    wprio, rprio;
  logic [PAYLOAD_BITS-1:0] wpay, rpay;
  logic                    accept;

  // Ring address of logical slot idx (idx < DEPTH).
  function automatic logic [AW-1:0] ring(input logic [AW-1:0] head,
                                         input logic [CW-1:0] idx);
    logic [AW:0] sum;
    sum = {1'b0, head} + (AW+1)'(idx);
    if (sum >= DepW) sum = sum - DepW;
    return sum[AW-1:0];
  endfunction

  spq_mem #(
    .DEPTH(DEPTH), .PRIO_BITS(PRIO_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wprio_i(wprio),
    .wpay_i (wpay),
    .raddr_i(raddr),
    .rprio_o(rprio),
    .rpay_o (rpay)
  );

  assign in_ready_o     = (state_q == S_IDLE) && (!ovalid_q || out_ready_i);
  assign accept         = in_valid_i && in_ready_o;
  assign out_valid_o    = ovalid_q;
  assign status_o       = ostat_q;
  assign out_priority_o = oprio_q;
  assign out_payload_o  = opay_q;
  assign occupancy_o    = oocc_q;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    head_d     = head_q;
    idx_d      = idx_q;
    wr_open_d  = wr_open_q;
    rd_open_d  = rd_open_q;
    active_d   = active_q;
    new_prio_d = new_prio_q;
    new_pay_d  = new_pay_q;
    ovalid_d   = ovalid_q && !out_ready_i;
    ostat_d    = ostat_q;
    oprio_d    = oprio_q;
    opay_d     = opay_q;
    oocc_d     = oocc_q;
    we         = 1'b0;
    waddr      = ring(head_q, idx_q);
    wprio      = new_prio_q;
    wpay       = new_pay_q;
    raddr      = head_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          // default: immediate result with no task
          oprio_d = '0;
          opay_d  = '0;
          ostat_d = ST_OK;
          case (cmd_i)
            CMD_INSERT: begin
              if (!active_q || !rd_open_q) begin
                ostat_d  = ST_REFUSED;
                oocc_d   = count_q;
                ovalid_d = 1'b1;
              end else if (count_q >= Full) begin
                ostat_d  = ST_FULL;
                oocc_d   = count_q;
                ovalid_d = 1'b1;
              end else begin
                new_prio_d = task_priority_i;
                new_pay_d  = task_payload_i;
                idx_d      = count_q;
                ovalid_d   = 1'b0;
                state_d    = S_INS_RD;
              end
            end
            CMD_REMOVE: begin
              if (count_q == '0) begin
                ostat_d  = (active_q && wr_open_q) ? ST_EMPTY_WAIT : ST_EMPTY_CLOSED;
                oocc_d   = count_q;
                ovalid_d = 1'b1;
              end else begin
                raddr    = head_q;
                ovalid_d = 1'b0;
                state_d  = S_REM;
              end
            end
            CMD_CLOSE_WRITER: begin
              wr_open_d = 1'b0;
              if (!rd_open_q) begin
                count_d  = '0;
                active_d = 1'b0;
              end
              oocc_d   = rd_open_q ? count_q : '0;
              ovalid_d = 1'b1;
            end
            default: begin
              rd_open_d = 1'b0;
              if (!wr_open_q) begin
                count_d  = '0;
                active_d = 1'b0;
              end
              oocc_d   = wr_open_q ? count_q : '0;
              ovalid_d = 1'b1;
            end
          endcase
        end
      end
      S_INS_RD: begin
        if (idx_q == '0) begin
          we      = 1'b1;
          count_d = count_q + 1'b1;
          ostat_d = ST_OK;
          oocc_d  = count_q + 1'b1;
          ovalid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          raddr   = ring(head_q, idx_q - 1'b1);
          state_d = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        we = 1'b1;
        if (rprio < new_prio_q) begin
          // lower priority moves one slot toward the tail
          wprio   = rprio;
          wpay    = rpay;
          idx_d   = idx_q - 1'b1;
          state_d = S_INS_RD;
        end else begin
          count_d  = count_q + 1'b1;
          ostat_d  = ST_OK;
          oocc_d   = count_q + 1'b1;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_REM: begin
        oprio_d  = rprio;
        opay_d   = rpay;
        ostat_d  = ST_OK;
        count_d  = count_q - 1'b1;
        oocc_d   = count_q - 1'b1;
        head_d   = ring(head_q, CW'(1));
        ovalid_d = 1'b1;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      head_q    <= '0;
      idx_q     <= '0;
      wr_open_q <= 1'b1;
      rd_open_q <= 1'b1;
      active_q  <= 1'b1;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      head_q    <= head_d;
      idx_q     <= idx_d;
      wr_open_q <= wr_open_d;
      rd_open_q <= rd_open_d;
      active_q  <= active_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_prio_q <= new_prio_d;
    new_pay_q  <= new_pay_d;
    ostat_q    <= ostat_d;
    oprio_q    <= oprio_d;
    opay_q     <= opay_d;
    oocc_q     <= oocc_d;
  end

endmodule

>>> tb/sv/testbench.sv
// Testbench for the stable priority pipe queue: ordering, ties, closes, status codes.
`timescale 1ns / 1ps
module testbench;
  import spq_pkg::*;

  localparam int unsigned QDEPTH   = DefDepth;
  localparam int unsigned CW       = $clog2(QDEPTH + 1);
  localparam int unsigned MAX_IDLE = 17;
  localparam int unsigned STALL_LIMIT = 3000;  // cycles with no request or result

  typedef struct packed {
    logic [StatusW-1:0]        status;
    logic [DefPrioBits-1:0]    prio;
    logic [DefPayloadBits-1:0] payload;
    logic [CW-1:0]             occupancy;
  } result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [CmdW-1:0]           cmd_i = CMD_INSERT;
  logic [DefPrioBits-1:0]    task_priority_i = '0;
  logic [DefPayloadBits-1:0] task_payload_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [StatusW-1:0]        status_o;
  logic [DefPrioBits-1:0]    out_priority_o;
  logic [DefPayloadBits-1:0] out_payload_o;
  logic [CW-1:0]             occupancy_o;

  stable_priority_pipe_queue dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .task_priority_i,
    .task_payload_i, .out_valid_o, .out_ready_i, .status_o, .out_priority_o,
    .out_payload_o, .occupancy_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow of the sorted store, head at index 0
  logic [DefPrioBits-1:0]    shadow_prio [QDEPTH];
  logic [DefPayloadBits-1:0] shadow_pay [QDEPTH];
  int unsigned shadow_count = 0;
  bit writer_open = 1'b1;
  bit reader_open = 1'b1;
  bit pipe_open = 1'b1;

  result_t pending_results[$];
  int unsigned errors = 0;
  int unsigned requests_sent = 0;
  int unsigned results_seen = 0;
  int unsigned status_hits [5] = '{default: 0};
  bit no_idle = 1'b0;  // set by phases that want back-to-back traffic

  function automatic int unsigned idle_draw();
    return no_idle ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  // Expected result of one command; updates the shadow state.
  function automatic result_t queue_outcome(logic [CmdW-1:0] c, logic [DefPrioBits-1:0] p,
                                            logic [DefPayloadBits-1:0] d);
    result_t r;
    int unsigned pos;
    r = '0;
    r.status = ST_OK;
    case (c)
      CMD_INSERT: begin
        if (!pipe_open || !reader_open) begin
          r.status = ST_REFUSED;
        end else if (shadow_count >= QDEPTH) begin
          r.status = ST_FULL;
        end else begin
          // behind every entry of equal or higher priority: keeps arrival order on ties
          pos = 0;
          while (pos < shadow_count && shadow_prio[pos] >= p) pos++;
          for (int i = shadow_count; i > pos; i--) begin
            shadow_prio[i] = shadow_prio[i-1];
            shadow_pay[i]  = shadow_pay[i-1];
          end
          shadow_prio[pos] = p;
          shadow_pay[pos]  = d;
          shadow_count++;
        end
      end
      CMD_REMOVE: begin
        if (shadow_count == 0) begin
          r.status = (pipe_open && writer_open) ? ST_EMPTY_WAIT : ST_EMPTY_CLOSED;
        end else begin
          r.prio    = shadow_prio[0];
          r.payload = shadow_pay[0];
          for (int i = 1; i < shadow_count; i++) begin
            shadow_prio[i-1] = shadow_prio[i];
            shadow_pay[i-1]  = shadow_pay[i];
          end
          shadow_count--;
        end
      end
      default: begin
        if (c == CMD_CLOSE_WRITER) writer_open = 1'b0;
        else reader_open = 1'b0;
        // both ends gone: queue dropped, pipe dead for good
        if (!writer_open && !reader_open) begin
          shadow_count = 0;
          pipe_open = 1'b0;
        end
      end
    endcase
    r.occupancy = shadow_count[CW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("mismatch on result %0d: %s got %0h expected %0h", results_seen, field, got, want);
    errors++;
  endtask

  // Sends one request; valid stays up across back-to-back requests.
  task automatic send_request(logic [CmdW-1:0] c, logic [DefPrioBits-1:0] p,
                              logic [DefPayloadBits-1:0] d);
    int unsigned gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= c;
    task_priority_i <= p;
    task_payload_i  <= d;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    pending_results.push_back(queue_outcome(c, p, d));
    requests_sent++;
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Mix of tie-heavy, extreme and spread priorities
  function automatic logic [DefPrioBits-1:0] pick_priority();
    case ($urandom_range(0, 3))
      0: return DefPrioBits'($urandom_range(0, 3));
      1: return $urandom_range(0, 1) ? 8'hff : 8'h00;
      2: return DefPrioBits'(100 + $urandom_range(0, 3));
      default: return DefPrioBits'($urandom());
    endcase
  endfunction

  task automatic random_burst(int unsigned n, bit allow_close);
    int unsigned insert_pct;
    int unsigned roll;
    insert_pct = $urandom_range(20, 80);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 40 == 0) insert_pct = $urandom_range(20, 80);
      roll = $urandom_range(0, 99);
      if (allow_close && roll < 6) begin
        send_request(roll < 3 ? CMD_CLOSE_WRITER : CMD_CLOSE_READER,
                     DefPrioBits'($urandom()), $urandom());
      end else if (roll < insert_pct) begin
        send_request(CMD_INSERT, pick_priority(), $urandom());
      end else begin
        send_request(CMD_REMOVE, DefPrioBits'($urandom()), $urandom());
      end
    end
  endtask

  // Result side: random back-pressure, in-order compare
  int unsigned rx_wait = 0;
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no progress for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("unexpected result %0d with no request outstanding", results_seen);
          errors++;
        end else begin
          result_t want;
          want = pending_results.pop_front();
          if (status_o != want.status)
            report_mismatch("status", 64'(status_o), 64'(want.status));
          if (out_priority_o != want.prio)
            report_mismatch("priority", 64'(out_priority_o), 64'(want.prio));
          if (out_payload_o != want.payload)
            report_mismatch("payload", 64'(out_payload_o), 64'(want.payload));
          if (occupancy_o != want.occupancy)
            report_mismatch("occupancy", 64'(occupancy_o), 64'(want.occupancy));
          if (want.status <= ST_EMPTY_CLOSED) status_hits[want.status]++;
        end
        rx_wait = idle_draw();
        out_ready_i <= (rx_wait == 0);
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready_i <= (rx_wait == 0);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic test_empty_and_extremes();
    send_request(CMD_REMOVE, 8'hff, '1);           // empty, pipe open: wait status
    send_request(CMD_INSERT, 8'h00, 32'h0);
    send_request(CMD_INSERT, 8'hff, 32'hffff_ffff);
    send_request(CMD_INSERT, 8'h80, 32'h5555_aaaa);
    send_request(CMD_INSERT, 8'h80, 32'haaaa_5555); // tie, must come out second
    repeat (5) send_request(CMD_REMOVE, 8'h00, 32'h0);
    wait_all_results();
  endtask

  task automatic test_fill_and_ties();
    no_idle = 1'b1;
    for (int i = 0; i < QDEPTH; i++)
      send_request(CMD_INSERT, DefPrioBits'(7 * (i % 3)), DefPayloadBits'(i));
    send_request(CMD_INSERT, 8'hff, 32'hdead_beef); // full, dropped
    send_request(CMD_INSERT, 8'h00, 32'h1);         // full, dropped
    no_idle = 1'b0;
    for (int i = 0; i < QDEPTH; i++) send_request(CMD_REMOVE, 8'h00, 32'h0);
    wait_all_results();
  endtask

  task automatic test_random_open();
    for (int b = 0; b < 20; b++) begin
      no_idle = (b % 5 == 2);
      random_burst(45, 1'b0);
      if (b % 7 == 3) wait_all_results();  // let the receiver catch up fully
    end
    no_idle = 1'b0;
    wait_all_results();
  endtask

  task automatic test_writer_closed();
    send_request(CMD_CLOSE_WRITER, 8'h00, 32'h0);
    send_request(CMD_CLOSE_WRITER, 8'hff, '1);      // repeat close saturates
    random_burst(150, 1'b0);                        // tasks still flow, empty remove closed
    while (shadow_count > 0) send_request(CMD_REMOVE, 8'h00, 32'h0);
    send_request(CMD_REMOVE, 8'h00, 32'h0);
    send_request(CMD_INSERT, 8'h42, 32'h1234_5678);
    send_request(CMD_INSERT, 8'h43, 32'h8765_4321);
    wait_all_results();
  endtask

  task automatic test_pipe_closed();
    send_request(CMD_CLOSE_READER, 8'h00, 32'h0);   // both closed: queue dropped
    send_request(CMD_INSERT, 8'hff, '1);            // refused
    send_request(CMD_REMOVE, 8'h00, 32'h0);         // empty, closed
    random_burst(140, 1'b1);
    wait_all_results();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_extremes();
    test_fill_and_ties();
    test_random_open();
    test_writer_closed();
    test_pipe_closed();
    repeat (60) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0d results never arrived", pending_results.size());
      errors += pending_results.size();
    end
    $display("covered %0d requests, %0d results, %0d mismatches", requests_sent,
             results_seen, errors);
    $display("status mix ok/refused/full/wait/closed: %0d %0d %0d %0d %0d", status_hits[0],
             status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> stable_priority_pipe_queue.f
design/spq_pkg.sv
design/spq_mem.sv
design/stable_priority_pipe_queue.sv
tb/sv/testbench.sv
